>>> rtl/hcr_pkg.sv
// Shared constants, tables and types for the height colour ramp.
package hcr_pkg;

    // Level format: Q1.16, one is 65536, clamped level needs 17 bits
    localparam int LEVEL_W = 17;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;

    localparam int NUM_BANDS = 5;
    localparam int NUM_CH    = 3;

    // Band codes
    localparam logic [2:0] BAND_DEEP   = 3'd0;
    localparam logic [2:0] BAND_SAND   = 3'd1;
    localparam logic [2:0] BAND_GRASS  = 3'd2;
    localparam logic [2:0] BAND_FOREST = 3'd3;
    localparam logic [2:0] BAND_SNOW   = 3'd4;

    // Channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Breakpoints 0.3, 0.45, 0.7, 0.85 in Q0.16
    localparam logic [LEVEL_W-1:0] BP_SAND   = 17'd19661;
    localparam logic [LEVEL_W-1:0] BP_GRASS  = 17'd29491;
    localparam logic [LEVEL_W-1:0] BP_FOREST = 17'd45875;
    localparam logic [LEVEL_W-1:0] BP_SNOW   = 17'd55706;

    // Band widths in Q0.16
    localparam int W_DEEP   = 19661;
    localparam int W_SAND   = 9830;
    localparam int W_GRASS  = 16384;
    localparam int W_FOREST = 9831;
    localparam int W_SNOW   = 9830;

    localparam int BAND_W [NUM_BANDS] = '{W_DEEP, W_SAND, W_GRASS, W_FOREST, W_SNOW};

    // Offset within a band is below the widest band width
    localparam int D_W = 15;
    // Scaled numerator 255*num + den/2 stays below 2^30
    localparam int X_W = 30;
    localparam int X_SHIFT = 30;
    localparam int TWO_X = 2**X_SHIFT;
    // Reciprocal multiplier and denominator widths
    localparam int M_W   = 11;
    localparam int DEN_W = 21;
    // Quotient estimate may overshoot by one, so up to 256
    localparam int Q_W   = 9;
    localparam int SLOPE_W = 15;

    // Endpoint colours in hundredths: start and end of each band
    localparam int RAMP_A [NUM_BANDS][NUM_CH] = '{
        '{10, 20, 40}, '{30, 50, 70}, '{70, 80, 40}, '{30, 95, 20}, '{80, 80, 80}
    };
    localparam int RAMP_B [NUM_BANDS][NUM_CH] = '{
        '{30, 50, 70}, '{70, 80, 40}, '{30, 95, 20}, '{20, 65, 30}, '{100, 100, 100}
    };

    // Denominator 100*W per band
    localparam logic [DEN_W-1:0] DEN [NUM_BANDS] = '{
        21'(100 * W_DEEP), 21'(100 * W_SAND), 21'(100 * W_GRASS),
        21'(100 * W_FOREST), 21'(100 * W_SNOW)
    };

    // floor(2^30 / den) + 1: estimate is exact or one high
    localparam logic [M_W-1:0] RECIP_M [NUM_BANDS] = '{
        11'(TWO_X / (100 * W_DEEP) + 1),
        11'(TWO_X / (100 * W_SAND) + 1),
        11'(TWO_X / (100 * W_GRASS) + 1),
        11'(TWO_X / (100 * W_FOREST) + 1),
        11'(TWO_X / (100 * W_SNOW) + 1)
    };

    // Constant part of the scaled numerator: W*(255*a + 50)
    function automatic logic [X_W-1:0] ramp_base(input logic [2:0] band,
                                                  input logic [1:0] ch);
        ramp_base = X_W'(BAND_W[band] * (255 * RAMP_A[band][ch] + 50));
    endfunction

    // Slope of the scaled numerator per unit offset: 255*(b - a)
    function automatic logic signed [SLOPE_W-1:0] ramp_slope(input logic [2:0] band,
                                                             input logic [1:0] ch);
        ramp_slope = SLOPE_W'(255 * (RAMP_B[band][ch] - RAMP_A[band][ch]));
    endfunction

    // Stage advance strobes and the band as it travels down the pipe
    typedef struct packed {
        logic       adv3;
        logic       adv4;
        logic       adv5;
        logic [2:0] band2;
        logic [2:0] band3;
        logic [2:0] band4;
    } t_lerp_ctl;

endpackage

>>> rtl/hcr_lerp_chan.sv
// One colour channel: interpolation, reciprocal divide and rounding correction.
module hcr_lerp_chan
    import hcr_pkg::*;
(
    input  logic             i_clk,
    input  t_lerp_ctl        i_ctl,
    input  logic [1:0]       i_chan,
    input  logic [D_W-1:0]   i_d,
    output logic [7:0]       o_chan
);

    logic [X_W-1:0]       r_x3;
    logic [X_W-1:0]       r_x4;
    logic [Q_W-1:0]       r_q4;
    logic [7:0]           r_q5;

    logic signed [31:0]   w_slope;
    logic signed [31:0]   w_x_full;
    logic [X_W+M_W-1:0]   w_est;
    logic [X_W-1:0]       w_back;
    logic [Q_W-1:0]       w_q;

    // Stage 3: scaled numerator = base + slope*d, all at 32 bits signed
    assign w_slope  = 32'(ramp_slope(i_ctl.band2, i_chan));
    assign w_x_full = $signed({2'b00, ramp_base(i_ctl.band2, i_chan)})
                    + w_slope * $signed({17'd0, i_d});

    // Stage 4: quotient estimate by reciprocal multiply
    assign w_est = (X_W+M_W)'(r_x3) * (X_W+M_W)'(RECIP_M[i_ctl.band3]);

    // Stage 5: step back by one where the estimate overshoots
    assign w_back = X_W'(r_q4) * X_W'(DEN[i_ctl.band4]);
    assign w_q    = (w_back > r_x4) ? r_q4 - 1'b1 : r_q4;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv3) begin
            r_x3 <= w_x_full[X_W-1:0];
        end
        if (i_ctl.adv4) begin
            r_x4 <= r_x3;
            r_q4 <= w_est[X_SHIFT+Q_W-1:X_SHIFT];
        end
        if (i_ctl.adv5) begin
            r_q5 <= w_q[7:0];
        end
    end

    assign o_chan = r_q5;

endmodule

>>> rtl/height_color_ramp_unit.sv
// Top level: height sample to banded RGB colour ramp, five-stage pipeline.
// Results pass through five register stages before o_valid rises.
// Throughput: one request per cycle; a full stage holds until the next can take it.
// Stages: scale and clamp, band select, interpolate, reciprocal multiply, round fix.
// Reset (synchronous, active low) empties the pipe and sets the reciprocal to 65536.
module height_color_ramp_unit
    import hcr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [31:0]         i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_height_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [2:0]          o_band
);

    logic [31:0]         r_recip;
    logic                r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [LEVEL_W-1:0]  r_level1;
    logic [2:0]          r_band2, r_band3, r_band4, r_band5;
    logic [D_W-1:0]      r_d2;

    logic                w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic [46:0]         w_prod;
    logic [LEVEL_W-1:0]  n_level;
    logic [2:0]          n_band;
    logic [LEVEL_W-1:0]  w_lo;
    logic [LEVEL_W-1:0]  w_d;
    t_lerp_ctl           w_ctl;

    // Per-stage ready: a stage takes data when empty or when it drains
    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip <= 32'd65536;
        end else if (i_cfg_wr_en) begin
            r_recip <= i_cfg_wr_data;
        end
    end

    // Stage 1: scale to Q1.16 and clamp; zero or negative gives level 0
    assign w_prod = 47'(i_height_sample[14:0]) * 47'(r_recip);

    always_comb begin
        if (i_height_sample[15]) begin
            n_level = '0;
        end else if (w_prod[46:16] > 31'(LEVEL_ONE)) begin
            n_level = LEVEL_ONE;
        end else begin
            n_level = w_prod[16+LEVEL_W-1:16];
        end
    end

    // Stage 2: band select and offset within the band
    always_comb begin
        if (r_level1 < BP_SAND) begin
            n_band = BAND_DEEP;
            w_lo   = '0;
        end else if (r_level1 < BP_GRASS) begin
            n_band = BAND_SAND;
            w_lo   = BP_SAND;
        end else if (r_level1 < BP_FOREST) begin
            n_band = BAND_GRASS;
            w_lo   = BP_GRASS;
        end else if (r_level1 < BP_SNOW) begin
            n_band = BAND_FOREST;
            w_lo   = BP_FOREST;
        end else begin
            n_band = BAND_SNOW;
            w_lo   = BP_SNOW;
        end
        w_d = r_level1 - w_lo;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // Payload of the first two stages and the band down the pipe
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_level1 <= n_level;
        end
        if (w_rdy2) begin
            r_band2 <= n_band;
            r_d2    <= w_d[D_W-1:0];
        end
        if (w_rdy3) r_band3 <= r_band2;
        if (w_rdy4) r_band4 <= r_band3;
        if (w_rdy5) r_band5 <= r_band4;
    end

    assign w_ctl.adv3  = w_rdy3;
    assign w_ctl.adv4  = w_rdy4;
    assign w_ctl.adv5  = w_rdy5;
    assign w_ctl.band2 = r_band2;
    assign w_ctl.band3 = r_band3;
    assign w_ctl.band4 = r_band4;

    // Stages 3 to 5, one lane per channel
    hcr_lerp_chan u_red (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_chan (CH_RED),
        .i_d    (r_d2),
        .o_chan (o_red)
    );

    hcr_lerp_chan u_green (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_chan (CH_GREEN),
        .i_d    (r_d2),
        .o_chan (o_green)
    );

    hcr_lerp_chan u_blue (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_chan (CH_BLUE),
        .i_d    (r_d2),
        .o_chan (o_blue)
    );

    assign o_valid = r_v5;
    assign o_band  = r_band5;

endmodule

>>> rtl/hcr_checker.sv
// Port-level checks for the height colour ramp, bound to the top level.
module hcr_checker
    import hcr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic [2:0]  o_band
);

    // A result request holds until it is taken
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result request dropped while stalled");

    // Band code is always one of the five bands
    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_band <= BAND_SNOW))
        else $error("band code out of range");

    // Snow runs from 0.8 to 1.0 grey, so every channel is at least 204
    a_snow_bright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_band == BAND_SNOW) |->
            (o_red >= 8'd204) && (o_green >= 8'd204) && (o_blue >= 8'd204))
        else $error("snow colour too dark");

    // With the output empty the whole pipe can take a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input not ready with empty output stage");

endmodule

bind height_color_ramp_unit hcr_checker u_hcr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_red   (o_red),
    .o_green (o_green),
    .o_blue  (o_blue),
    .o_band  (o_band)
);

>>> tb/height_color_ramp_unit_tb.sv
// Self-checking testbench for the height colour ramp: scaling, banding and RGB interpolation.
`timescale 1ns / 1ps

module height_color_ramp_unit_tb
    import hcr_pkg::*;
;

    localparam int  CLK_PERIOD      = 20;
    localparam int  PIPE_LATENCY    = 5;
    localparam int  HOLD_OFF_CYCLES = 80;
    localparam int  TIMEOUT_CYCLES  = 1_000_000;
    localparam int  RAND_PHASES     = 10;
    localparam int  RAND_PER_PHASE  = 125;

    // Band limits in Q1.16 and endpoint colours in hundredths
    localparam int BAND_TOP  [NUM_BANDS] = '{BP_SAND, BP_GRASS, BP_FOREST, BP_SNOW, LEVEL_ONE};
    localparam int BAND_BASE [NUM_BANDS] = '{0, BP_SAND, BP_GRASS, BP_FOREST, BP_SNOW};
    localparam int COL_START [NUM_BANDS][NUM_CH] = '{
        '{10, 20, 40}, '{30, 50, 70}, '{70, 80, 40}, '{30, 95, 20}, '{80, 80, 80}
    };
    localparam int COL_END [NUM_BANDS][NUM_CH] = '{
        '{30, 50, 70}, '{70, 80, 40}, '{30, 95, 20}, '{20, 65, 30}, '{100, 100, 100}
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] band;
    } t_ramp_color;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_wr_en     = 1'b0;
    logic [31:0]        i_cfg_wr_data   = '0;
    logic               i_valid         = 1'b0;
    logic signed [15:0] i_height_sample = '0;
    logic               i_ready         = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;
    logic [2:0]         o_band;

    t_ramp_color expected_colors [$];
    logic [31:0] recip_shadow   = 32'd65536;
    int          error_count    = 0;
    int          heights_sent   = 0;
    int          colors_checked = 0;
    int          recip_writes   = 0;
    bit          tx_steady      = 1'b0;
    bit          rx_steady      = 1'b0;
    bit          hold_off_req   = 1'b0;

    height_color_ramp_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_height_sample (i_height_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_band          (o_band)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // One channel: linear blend inside the band, rounded half up to unorm
    function automatic logic [7:0] blend_unorm(input int a, input int b,
                                               input longint d, input longint w);
        longint num;
        longint den;
        longint v;
        num = a * w + (b - a) * d;
        den = 100 * w;
        if (num < 0)
            num = 0;
        v = (255 * num + den / 2) / den;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    function automatic t_ramp_color predict_color(input logic signed [15:0] sample,
                                                  input logic [31:0] recip);
        logic [63:0] prod;
        longint      lvl;
        int          b;
        t_ramp_color c;
        lvl = 0;
        if (sample > 0) begin
            prod = ({48'd0, sample[15:0]} * {32'd0, recip}) >> 16;
            lvl  = (prod > 64'd65536) ? 65536 : longint'(prod);
        end
        b = BAND_DEEP;
        while (b < BAND_SNOW && lvl >= BAND_TOP[b])
            b++;
        c.red   = blend_unorm(COL_START[b][CH_RED], COL_END[b][CH_RED],
                              lvl - BAND_BASE[b], BAND_TOP[b] - BAND_BASE[b]);
        c.green = blend_unorm(COL_START[b][CH_GREEN], COL_END[b][CH_GREEN],
                              lvl - BAND_BASE[b], BAND_TOP[b] - BAND_BASE[b]);
        c.blue  = blend_unorm(COL_START[b][CH_BLUE], COL_END[b][CH_BLUE],
                              lvl - BAND_BASE[b], BAND_TOP[b] - BAND_BASE[b]);
        c.band  = 3'(b);
        return c;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    // Random sample: raw 16 bits, useful positive range, or close to a breakpoint
    function automatic logic signed [15:0] pick_sample(input logic [31:0] recip);
        longint r;
        longint top;
        longint s;
        int     sel;
        int     off;
        r   = recip;
        sel = $urandom_range(0, 9);
        off = $urandom_range(0, 4);
        if (sel < 4 || r == 0)
            return 16'($urandom_range(0, 65535));
        if (sel < 7) begin
            top = (longint'(65537) << 16) / r;
            if (top > 32767)
                top = 32767;
            return 16'($urandom_range(0, int'(top)));
        end
        top = BAND_TOP[$urandom_range(0, NUM_BANDS - 1)];
        s   = ((top << 16) + r - 1) / r + off - 2;
        if (s < 1)
            s = 1;
        if (s > 32767)
            s = 32767;
        return 16'(s);
    endfunction

    // Offer one request, record its expected colour when it is taken
    task automatic send_height(input logic signed [15:0] sample);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_height_sample <= sample;
        @(negedge i_clk);
        while (o_ready !== 1'b1)
            @(negedge i_clk);
        expected_colors.insert(expected_colors.size(), predict_color(sample, recip_shadow));
        heights_sent++;
        @(posedge i_clk);
    endtask

    // Register write once the pipe has drained
    task automatic write_recip(input logic [31:0] value);
        i_valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        recip_shadow   = value;
        recip_writes++;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Result checker: compare each taken result with the oldest expectation
    always @(negedge i_clk) begin
        t_ramp_color want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_colors.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual r%0d g%0d b%0d band %0d",
                         $time, o_red, o_green, o_blue, o_band);
                error_count++;
            end else begin
                want = expected_colors.pop_front();
                check_field("red", want.red, o_red);
                check_field("green", want.green, o_green);
                check_field("blue", want.blue, o_blue);
                check_field("band", {5'd0, want.band}, {5'd0, o_band});
                colors_checked++;
            end
        end
    end

    // Receiver: random back-pressure, steady stretches and one long hold-off
    initial begin : ready_driver
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (rx_steady || $urandom_range(0, 3) != 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end
        end
    end

    // Reset value of the scale, sign handling and the two lower breakpoints
    task automatic test_reset_scale();
        send_height(16'sd0);
        send_height(16'sd1);
        send_height(-16'sd1);
        send_height(-16'sd32768);
        send_height(16'sd32767);
        send_height(16'sd19660);
        send_height(16'sd19661);
        send_height(16'sd29490);
        send_height(16'sd29491);
    endtask

    // With a sample of one the level equals the upper half of the scale
    task automatic test_upper_breakpoints();
        write_recip(32'(BP_FOREST - 1) << 16);
        send_height(16'sd1);
        write_recip(32'(BP_FOREST) << 16);
        send_height(16'sd1);
        write_recip(32'(BP_SNOW - 1) << 16);
        send_height(16'sd1);
        write_recip(32'(BP_SNOW) << 16);
        send_height(16'sd1);
    endtask

    // Level reaching exactly one and beyond it
    task automatic test_clamp();
        write_recip(32'd262144);
        send_height(16'sd16383);
        send_height(16'sd16384);
        send_height(16'sd16385);
        send_height(16'sd32767);
    endtask

    // Zero and all-ones scale
    task automatic test_recip_extremes();
        write_recip(32'd0);
        send_height(16'sd32767);
        send_height(16'sd1);
        send_height(-16'sd1);
        write_recip(32'hFFFF_FFFF);
        send_height(16'sd1);
        send_height(16'sd2);
        send_height(16'sd32767);
        send_height(-16'sd32768);
    endtask

    // Random samples over a range of scale settings
    task automatic test_random_sweep();
        logic [31:0] recip;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       recip = 32'd65536;
                1:       recip = 32'd131072;
                2:       recip = 32'd131076;
                3:       recip = 32'd1;
                4:       recip = 32'd0;
                5:       recip = 32'hFFFF_FFFF;
                6:       recip = $urandom();
                default: recip = $urandom_range(65536, 524288);
            endcase
            write_recip(recip);
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_height(pick_sample(recip));
        end
    endtask

    // Both sides flat out, no gaps at all
    task automatic test_back_to_back();
        write_recip(32'd131076);
        rx_steady = 1'b1;
        tx_steady = 1'b1;
        for (int n = 0; n < 60; n++)
            send_height(pick_sample(recip_shadow));
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver stops for a long stretch while requests keep coming
    task automatic test_output_hold_off();
        write_recip(32'd150000);
        hold_off_req = 1'b1;
        tx_steady    = 1'b1;
        for (int n = 0; n < 40; n++)
            send_height(pick_sample(recip_shadow));
        tx_steady = 1'b0;
    endtask

    initial begin : main_seq
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_scale();
        test_upper_breakpoints();
        test_clamp();
        test_recip_extremes();
        test_random_sweep();
        test_back_to_back();
        test_output_hold_off();

        // Drain the pipe, then watch for stray results before the summary
        i_valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY * 2) @(posedge i_clk);

        $display("Run covered %0d height requests, %0d colours checked, %0d scale writes,",
                 heights_sent, colors_checked, recip_writes);
        $display("all five bands, clamping, zero and all-ones scale, and output back-pressure.");
        if (error_count == 0) begin
            $display("height_color_ramp_unit_tb: PASS");
        end else begin
            $display("height_color_ramp_unit_tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
        $display("Timeout with %0d results still outstanding", expected_colors.size());
        $display("height_color_ramp_unit_tb: FAIL");
        $finish;
    end

endmodule
